/* sv/chw_pkg.sv */
// chw_pkg: shared types and codes for the chained hash word set.
// Used by chw_front, chw_back, the top level and the bench; depends on nothing.
`timescale 1ns / 1ps

package chw_pkg;

    localparam int CHAR_W   = 8;
    localparam int HASH_W   = 64;
    localparam int POWER_W  = 32;
    localparam int STATUS_W = 3;
    localparam int BKT_OUT_W = 10;

    // Word operation, taken from the beat that carries the last character.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_e_t;

    typedef struct packed {
        logic                     cmd;
        logic signed [CHAR_W-1:0] character;
        logic                     last_char;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [BKT_OUT_W-1:0] bucket_index;
    } out_t;

endpackage

/* sv/chw_ram.sv */
// chw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module chw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/chw_front.sv */
// chw_front: takes character beats, keeps the word text and the base-31 hash.
// Depends on chw_pkg; hands finished words to the queue.
`timescale 1ns / 1ps

module chw_front #(
    parameter int MAX_CHARS = 31
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  chw_pkg::in_t                         item,
    output logic                                 push,
    output logic                                 push_cmd,
    output logic [$clog2(MAX_CHARS+1)-1:0]       push_len,
    output logic [chw_pkg::HASH_W-1:0]           push_hash,
    output logic [MAX_CHARS-1:0][chw_pkg::CHAR_W-1:0] push_chars
);

    import chw_pkg::*;

    localparam int LW = $clog2(MAX_CHARS + 1);
    localparam int CW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

    logic [LW-1:0]                    count_reg, count_next;
    logic [HASH_W-1:0]                hash_reg, hash_next;
    logic [POWER_W-1:0]               power_reg, power_next;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_reg, chars_next;

    logic                     keep;
    logic signed [39:0]       prod;
    logic [HASH_W-1:0]        hash_upd;
    logic [POWER_W-1:0]       power_upd;
    logic [LW-1:0]            count_upd;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_upd;

    always_comb
    begin
        keep      = (count_reg < LW'(MAX_CHARS));
        prod      = $signed(item.character) * $signed(power_reg);
        hash_upd  = hash_reg;
        power_upd = power_reg;
        count_upd = count_reg;
        chars_upd = chars_reg;
        if (keep)
        begin
            hash_upd  = hash_reg + {{(HASH_W-40){prod[39]}}, prod};
            power_upd = (power_reg << 5) - power_reg;   // times 31, wraps
            count_upd = count_reg + LW'(1);
            chars_upd[count_reg[CW-1:0]] = item.character;
        end

        push       = accept && item.last_char;
        push_cmd   = item.cmd;
        push_len   = count_upd;
        push_hash  = hash_upd;
        push_chars = chars_upd;

        count_next = count_reg;
        hash_next  = hash_reg;
        power_next = power_reg;
        chars_next = chars_reg;
        if (accept)
        begin
            chars_next = chars_upd;
            if (item.last_char)
            begin
                count_next = '0;
                hash_next  = '0;
                power_next = POWER_W'(1);
            end
            else
            begin
                count_next = count_upd;
                hash_next  = hash_upd;
                power_next = power_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hash_reg  <= '0;
            power_reg <= POWER_W'(1);
        end
        else
        begin
            count_reg <= count_next;
            hash_reg  <= hash_next;
            power_reg <= power_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

endmodule

/* sv/chw_queue.sv */
// chw_queue: two-entry word queue between the front and the back.
// No dependencies.
`timescale 1ns / 1ps

module chw_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);

    logic [WIDTH-1:0] entry_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        empty    = (cnt_reg == 2'd0);
        full     = (cnt_reg == 2'd2);
        pop_data = entry_reg[rd_reg];
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

endmodule

/* sv/chw_back.sv */
// chw_back: bucket selection, chain walk, insert and result for each word.
// Depends on chw_pkg and chw_ram; takes words from chw_queue.
`timescale 1ns / 1ps

module chw_back #(
    parameter int BUCKETS     = 1024,
    parameter int WORDS       = 4096,
    parameter int CHAIN_DEPTH = 16,
    parameter int MAX_CHARS   = 31
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  logic                                 q_cmd,
    input  logic [$clog2(MAX_CHARS+1)-1:0]       q_len,
    input  logic [chw_pkg::HASH_W-1:0]           q_hash,
    input  logic [MAX_CHARS-1:0][chw_pkg::CHAR_W-1:0] q_chars,
    output logic                                 pop,
    output logic                                 clearing,
    output logic                                 done,
    output chw_pkg::out_t                        result
);

    import chw_pkg::*;

    localparam int LW  = $clog2(MAX_CHARS + 1);
    localparam int CW  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int BW  = $clog2(BUCKETS);
    localparam int FW  = $clog2(CHAIN_DEPTH + 1);
    localparam int WAW = $clog2(WORDS);
    localparam int UW  = $clog2(WORDS + 1);
    localparam int SAW = ((BUCKETS * CHAIN_DEPTH) > 1) ? $clog2(BUCKETS * CHAIN_DEPTH) : 1;
    localparam int CAW = ((WORDS * MAX_CHARS) > 1) ? $clog2(WORDS * MAX_CHARS) : 1;

    typedef enum logic [13:0] {
        S_CLEAR     = 14'b00000000000001,
        S_IDLE      = 14'b00000000000010,
        S_FILL      = 14'b00000000000100,
        S_FILL_WAIT = 14'b00000000001000,
        S_SLOT      = 14'b00000000010000,
        S_SLOT_WAIT = 14'b00000000100000,
        S_LEN       = 14'b00000001000000,
        S_LEN_WAIT  = 14'b00000010000000,
        S_CHR       = 14'b00000100000000,
        S_CHR_WAIT  = 14'b00001000000000,
        S_DECIDE    = 14'b00010000000000,
        S_WR_CHR    = 14'b00100000000000,
        S_WR_META   = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

    state_t                           state_reg, state_next;
    logic [BW-1:0]                    rem_reg, rem_next;
    logic                             cmd_reg, cmd_next;
    logic [LW-1:0]                    len_reg, len_next;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_reg, chars_next;
    logic [FW-1:0]                    fill_reg, fill_next;
    logic [FW-1:0]                    idx_reg, idx_next;
    logic [WAW-1:0]                   slot_reg, slot_next;
    logic [LW-1:0]                    k_reg, k_next;
    logic                             found_reg, found_next;
    logic [UW-1:0]                    words_reg, words_next;
    logic [BW-1:0]                    clr_reg, clr_next;
    logic [STATUS_W-1:0]              status_reg, status_next;

    // RAM ports
    logic           fill_we;
    logic [BW-1:0]  fill_waddr;
    logic [FW-1:0]  fill_wdata, fill_rdata;
    logic           slot_we;
    logic [SAW-1:0] slot_waddr, slot_raddr;
    logic [WAW-1:0] slot_rdata;
    logic           len_we;
    logic [LW-1:0]  len_rdata;
    logic           chr_we;
    logic [CAW-1:0] chr_waddr, chr_raddr;
    logic [CHAR_W-1:0] chr_rdata;

    chw_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (rem_reg),
        .rdata (fill_rdata)
    );

    chw_ram #(.WIDTH(WAW), .DEPTH(BUCKETS * CHAIN_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (words_reg[WAW-1:0]),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    chw_ram #(.WIDTH(LW), .DEPTH(WORDS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (words_reg[WAW-1:0]),
        .wdata (len_reg),
        .raddr (slot_reg),
        .rdata (len_rdata)
    );

    chw_ram #(.WIDTH(CHAR_W), .DEPTH(WORDS * MAX_CHARS)) u_chr_ram (
        .clk   (clk),
        .we    (chr_we),
        .waddr (chr_waddr),
        .wdata (chars_reg[k_reg[CW-1:0]]),
        .raddr (chr_raddr),
        .rdata (chr_rdata)
    );

    always_comb
    begin
        slot_raddr = SAW'(rem_reg) * SAW'(CHAIN_DEPTH) + SAW'(idx_reg);
        slot_waddr = SAW'(rem_reg) * SAW'(CHAIN_DEPTH) + SAW'(fill_reg);
        chr_raddr  = CAW'(slot_reg) * CAW'(MAX_CHARS) + CAW'(k_reg);
        chr_waddr  = CAW'(words_reg[WAW-1:0]) * CAW'(MAX_CHARS) + CAW'(k_reg);

        fill_we    = 1'b0;
        fill_waddr = rem_reg;
        fill_wdata = fill_reg + FW'(1);
        slot_we    = 1'b0;
        len_we     = 1'b0;
        chr_we     = 1'b0;
        pop        = 1'b0;

        state_next  = state_reg;
        rem_next    = rem_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        chars_next  = chars_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        k_next      = k_reg;
        found_next  = found_reg;
        words_next  = words_reg;
        clr_next    = clr_reg;
        status_next = status_reg;

        case (state_reg)
            S_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
                clr_next   = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = q_cmd;
                    len_next   = q_len;
                    chars_next = q_chars;
                    // BUCKETS is a power of two: the bucket is the low hash bits
                    rem_next   = q_hash[BW-1:0];
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                state_next = S_FILL_WAIT;
            end
            S_FILL_WAIT:
            begin
                fill_next  = fill_rdata;
                idx_next   = '0;
                found_next = 1'b0;
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                if (idx_reg == fill_reg)
                    state_next = S_DECIDE;
                else
                    state_next = S_SLOT_WAIT;
            end
            S_SLOT_WAIT:
            begin
                slot_next  = slot_rdata;
                state_next = S_LEN;
            end
            S_LEN:
            begin
                state_next = S_LEN_WAIT;
            end
            S_LEN_WAIT:
            begin
                k_next = '0;
                if (len_rdata != len_reg)
                begin
                    idx_next   = idx_reg + FW'(1);
                    state_next = S_SLOT;
                end
                else if (len_reg == '0)
                begin
                    found_next = 1'b1;
                    state_next = S_DECIDE;
                end
                else
                    state_next = S_CHR;
            end
            S_CHR:
            begin
                state_next = S_CHR_WAIT;
            end
            S_CHR_WAIT:
            begin
                if (chr_rdata != chars_reg[k_reg[CW-1:0]])
                begin
                    idx_next   = idx_reg + FW'(1);
                    state_next = S_SLOT;
                end
                else if (k_reg == len_reg - LW'(1))
                begin
                    found_next = 1'b1;
                    state_next = S_DECIDE;
                end
                else
                begin
                    k_next     = k_reg + LW'(1);
                    state_next = S_CHR;
                end
            end
            S_DECIDE:
            begin
                k_next     = '0;
                state_next = S_DONE;
                if (cmd_reg == CMD_LOOKUP)
                    status_next = found_reg ? ST_FOUND : ST_NOT_FOUND;
                else if (found_reg)
                    status_next = ST_PRESENT;
                else if (fill_reg == FW'(CHAIN_DEPTH) || words_reg == UW'(WORDS))
                    status_next = ST_FULL;
                else
                    state_next = S_WR_CHR;
            end
            S_WR_CHR:
            begin
                chr_we = 1'b1;
                k_next = k_reg + LW'(1);
                if (k_reg == len_reg - LW'(1))
                    state_next = S_WR_META;
            end
            S_WR_META:
            begin
                fill_we     = 1'b1;
                slot_we     = 1'b1;
                len_we      = 1'b1;
                words_next  = words_reg + UW'(1);
                status_next = ST_INSERTED;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        clearing            = (state_reg == S_CLEAR);
        done                = (state_reg == S_DONE);
        result.status       = status_reg;
        result.bucket_index = BKT_OUT_W'(rem_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            words_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            words_reg <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        cmd_reg    <= cmd_next;
        len_reg    <= len_next;
        chars_reg  <= chars_next;
        fill_reg   <= fill_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        k_reg      <= k_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

endmodule

/* sv/chained_hash_word_set.sv */
// chained_hash_word_set: top level of the chained hash word set.
// Depends on chw_pkg, chw_front, chw_queue, chw_back (and chw_ram below it).
//
// Usage
//   Input: one character beat per cycle on `in` (cmd, character, last_char),
//   taken on a rising edge with start high and busy low. The cmd of the beat
//   that carries last_char picks insert or lookup for the whole word.
//   Characters beyond MAX_CHARS are dropped, but last_char still ends the word.
//   Output: one result beat per word on `result` (status, bucket_index),
//   marked by `done` for exactly one cycle. The receiver cannot stall; it must
//   take the beat in that cycle. BUCKETS is a power of two; the bucket is the
//   low bits of the hash.
// Throughput and flow
//   Characters go in at one per cycle while the two-entry word queue has room
//   and the reset sweep is over. Per word the back end pops it, reads the
//   bucket fill, then per chain entry reads the slot and stored length and,
//   on a length match, compares the characters one at a time; it decides,
//   on insert writes the characters and then the fill, slot and length
//   entries, and gives the result. The chain walk through the registered RAM
//   reads sets the pace, so busy rises when two finished words are waiting.
// Reset
//   rst_n is asynchronous, active low. After it the back end sweeps the bucket
//   fill RAM, one bucket per cycle, with busy held high.

`timescale 1ns / 1ps

module chained_hash_word_set #(
    parameter int BUCKETS     = 1024,
    parameter int WORDS       = 4096,
    parameter int CHAIN_DEPTH = 16,
    parameter int MAX_CHARS   = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  chw_pkg::in_t  in,
    output logic          done,
    output chw_pkg::out_t result
);

    import chw_pkg::*;

    localparam int LW = $clog2(MAX_CHARS + 1);
    localparam int QW = 1 + LW + HASH_W + MAX_CHARS * CHAR_W;

    logic                             accept;
    logic                             push;
    logic                             push_cmd;
    logic [LW-1:0]                    push_len;
    logic [HASH_W-1:0]                push_hash;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] push_chars;

    logic [QW-1:0] q_in, q_out;
    logic          q_pop, q_empty, q_full;
    logic          clearing;

    logic                             q_cmd;
    logic [LW-1:0]                    q_len;
    logic [HASH_W-1:0]                q_hash;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] q_chars;

    // Front stalls only on a full word queue or during the post-reset sweep.
    // A word is pushed at most once per accepted beat, so the queue cannot
    // overflow while busy tracks its full flag.
    assign busy   = q_full || clearing;
    assign accept = start && !busy;

    chw_front #(.MAX_CHARS(MAX_CHARS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (in),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_len   (push_len),
        .push_hash  (push_hash),
        .push_chars (push_chars)
    );

    assign q_in = {push_cmd, push_len, push_hash, push_chars};

    chw_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {q_cmd, q_len, q_hash, q_chars} = q_out;

    chw_back #(
        .BUCKETS     (BUCKETS),
        .WORDS       (WORDS),
        .CHAIN_DEPTH (CHAIN_DEPTH),
        .MAX_CHARS   (MAX_CHARS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (q_cmd),
        .q_len    (q_len),
        .q_hash   (q_hash),
        .q_chars  (q_chars),
        .pop      (q_pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

    // A result beat never lasts more than one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // The word queue is never written while full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("word queue overflow");

    // No word is taken from the queue during the fill sweep.
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("word popped during fill sweep");

    // Status codes stay in the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= ST_FULL))
        else $error("status out of range");

endmodule

/* bench/chained_hash_word_set_tb.sv */
// chained_hash_word_set_tb: self-checking bench for the chained hash word set.
// Depends on chw_pkg and chained_hash_word_set; sends character beats and
// checks each word result against an in-bench model of the hash table.
`timescale 1ns / 1ps

module chained_hash_word_set_tb;
    import chw_pkg::*;

    localparam int BUCKETS     = 1024;
    localparam int WORDS       = 4096;
    localparam int CHAIN_DEPTH = 16;
    localparam int MAX_CHARS   = 31;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  in;
    logic done;
    out_t result;

    chained_hash_word_set #(
        .BUCKETS(BUCKETS),
        .WORDS(WORDS),
        .CHAIN_DEPTH(CHAIN_DEPTH),
        .MAX_CHARS(MAX_CHARS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .in(in),
        .done(done),
        .result(result)
    );

    // Table model state.
    logic [7:0]  cur_chars[MAX_CHARS];
    int          cur_len;
    logic [63:0] cur_hash;
    logic [31:0] cur_power;
    logic [7:0]  stored_text[WORDS][MAX_CHARS];
    int          stored_len[WORDS];
    int          chain_fill[BUCKETS];
    int          chain_word[BUCKETS][CHAIN_DEPTH];
    int          stored_words;

    out_t   pending_results[$];
    int     errors;
    int     results_seen;
    int     beats_sent;
    longint cycles;
    int     burst_left;

    // Dictionary of words reused for hits and duplicates.
    typedef struct {
        int         len;
        logic [7:0] c[40];
    } word_t;
    word_t vocab[$];

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    // Result checker: the block gives no backpressure, so every done cycle counts.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report("unexpected result, status", result.status, -1);
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report("status", result.status, want.status);
                if (result.bucket_index !== want.bucket_index)
                    report("bucket_index", result.bucket_index, want.bucket_index);
            end
        end
    end

    function automatic bit chain_has(int b);
        bit same;
        for (int i = 0; i < chain_fill[b]; i++)
        begin
            int w;
            w = chain_word[b][i];
            if (stored_len[w] == cur_len)
            begin
                same = 1'b1;
                for (int k = 0; k < cur_len; k++)
                    if (stored_text[w][k] != cur_chars[k])
                        same = 1'b0;
                if (same)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the model by one accepted beat; queue a result on word end.
    task automatic hash_beat(input in_t beat);
        out_t r;
        int   b;
        if (cur_len < MAX_CHARS)
        begin
            cur_hash  = cur_hash + 64'(longint'(beat.character) * longint'($signed(cur_power)));
            cur_power = cur_power * 32'd31;
            cur_chars[cur_len] = beat.character;
            cur_len++;
        end
        if (!beat.last_char)
            return;
        b = int'(cur_hash % BUCKETS);
        if (beat.cmd == CMD_LOOKUP)
            r.status = chain_has(b) ? ST_FOUND : ST_NOT_FOUND;
        else if (chain_has(b))
            r.status = ST_PRESENT;
        else if (chain_fill[b] >= CHAIN_DEPTH || stored_words >= WORDS)
            r.status = ST_FULL;
        else
        begin
            for (int k = 0; k < cur_len; k++)
                stored_text[stored_words][k] = cur_chars[k];
            stored_len[stored_words] = cur_len;
            chain_word[b][chain_fill[b]] = stored_words;
            chain_fill[b]++;
            stored_words++;
            r.status = ST_INSERTED;
        end
        r.bucket_index = b[9:0];
        pending_results.push_back(r);
        cur_len   = 0;
        cur_hash  = '0;
        cur_power = 32'd1;
    endtask

    // Drive one beat from a falling edge and hold it until accepted.
    task automatic send_beat(input logic cmd, input logic [7:0] ch, input logic last);
        in_t beat;
        int  gap;
        beat.cmd = cmd;
        beat.character = ch;
        beat.last_char = last;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1'b1;
        in    <= beat;
        do
            @(posedge clk);
        while (busy);
        hash_beat(beat);
        beats_sent++;
        @(negedge clk);
    endtask

    // Non-last characters carry a random cmd, since only the final one counts.
    task automatic send_word(input word_t w, input logic cmd);
        for (int i = 0; i < w.len; i++)
            send_beat(i == w.len - 1 ? cmd : logic'($urandom_range(0, 1)), w.c[i],
                      i == w.len - 1);
    endtask

    function automatic word_t random_word(int max_len);
        word_t w;
        w.len = $urandom_range(1, max_len);
        for (int i = 0; i < w.len; i++)
            w.c[i] = 8'($urandom);
        return w;
    endfunction

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic test_extremes();
        word_t w;
        // Single characters at the signed extremes and zero.
        w.len = 1;
        foreach (w.c[i]) w.c[i] = 8'h00;
        w.c[0] = 8'h7f; send_word(w, CMD_LOOKUP); send_word(w, CMD_INSERT);
        send_word(w, CMD_INSERT); send_word(w, CMD_LOOKUP);
        w.c[0] = 8'h80; send_word(w, CMD_INSERT); send_word(w, CMD_LOOKUP);
        w.c[0] = 8'hff; send_word(w, CMD_INSERT);
        w.c[0] = 8'h00; send_word(w, CMD_INSERT);
        // Long word: characters past the limit are dropped yet still end it.
        w.len = 36;
        for (int i = 0; i < 36; i++) w.c[i] = 8'($urandom);
        send_word(w, CMD_INSERT);
        w.c[35] = ~w.c[35];
        send_word(w, CMD_LOOKUP);
        w.len = 31;
        send_word(w, CMD_LOOKUP);
        drain();
    endtask

    // Fill one bucket past its chain depth: two-character words whose hash
    // c0 + 31*c1 lands in bucket 5, with c0 picked from the residue for each c1.
    task automatic test_full_chain();
        word_t w;
        int    made;
        int    r;
        w.len = 2;
        made  = 0;
        for (int c1 = -128; c1 < 128 && made < 18; c1++)
        begin
            r = (5 - 31 * c1) & 1023;
            if (r < 128 || r >= 896)
            begin
                w.c[1] = 8'(c1);
                w.c[0] = 8'((r < 128) ? r : r - 1024);
                send_word(w, CMD_INSERT);
                made++;
            end
        end
        drain();
    endtask

    task automatic test_random();
        word_t w;
        for (int n = 0; n < 60; n++)
            vocab.push_back(random_word($urandom_range(0, 9) == 0 ? 34 : 6));
        while (beats_sent < 1300)
        begin
            case ($urandom_range(0, 4))
                0, 1: w = vocab[$urandom_range(0, vocab.size() - 1)];
                2: w = random_word(5);
                3: w = random_word(2);
                default: w = random_word(34);
            endcase
            send_word(w, logic'($urandom_range(0, 1)));
            if ($urandom_range(0, 150) == 0)
                drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in = '0;
        cycles = 0;
        errors = 0;
        results_seen = 0;
        beats_sent = 0;
        burst_left = 0;
        cur_len = 0;
        cur_hash = '0;
        cur_power = 32'd1;
        stored_words = 0;
        foreach (chain_fill[i]) chain_fill[i] = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_full_chain();
        test_random();
        $display("Sent %0d character beats, checked %0d word results, %0d words stored.",
                 beats_sent, results_seen, stored_words);
        $display("Covered extremes, overlong words, duplicates, lookups and full chains.");
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/chw_pkg.sv
sv/chw_ram.sv
sv/chw_front.sv
sv/chw_queue.sv
sv/chw_back.sv
sv/chained_hash_word_set.sv
bench/chained_hash_word_set_tb.sv
